[hdl/pfc_pkg.sv]
// Package with format codes, types and helpers for the pixel converter.
package pfc_pkg;

    typedef enum logic [3:0] {
        FMT_BGRA8   = 4'd0,
        FMT_R8      = 4'd1,
        FMT_RG8     = 4'd2,
        FMT_R16U    = 4'd3,
        FMT_R16F    = 4'd4,
        FMT_RG16U   = 4'd5,
        FMT_RG16F   = 4'd6,
        FMT_RGBA16U = 4'd7,
        FMT_RGBA16F = 4'd8,
        FMT_R32F    = 4'd9,
        FMT_RG32F   = 4'd10,
        FMT_RGB32F  = 4'd11,
        FMT_RGBA32F = 4'd12,
        FMT_B10G11R11 = 4'd13,
        FMT_OTHER   = 4'd14,
        FMT_UNUSED  = 4'd15
    } t_fmt;

    // Kind of conversion one channel lane performs.
    typedef enum logic [2:0] {
        K_ZERO  = 3'd0,
        K_ONE   = 3'd1,
        K_BYTE  = 3'd2,
        K_UN16  = 3'd3,
        K_FLOAT = 3'd4
    } t_kind;

    // A channel after decode: a significand of up to 24 bits and a right shift.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_val;
        logic [15:0] un16;
        logic        sat;     // value is 1 or more
        logic        zero;    // value reads 0
        logic [23:0] mant;
        logic [5:0]  sh;      // right shift, 24..63, or 0 when unused
    } t_chan;

endpackage

[hdl/pfc_lane.sv]
// One channel lane: decode, scale by 255 and round, in three register stages.
module pfc_lane (
    input  logic                 i_clk,
    input  logic                 i_en0,
    input  logic                 i_en1,
    input  logic                 i_en2,
    input  pfc_pkg::t_kind       i_kind,
    input  logic [31:0]          i_bits,
    output logic [7:0]           o_val
);
    import pfc_pkg::*;

    // Float channels arrive in single-precision form; the top level widens
    // half floats and packed unsigned floats before they reach the lane.
    t_chan n_c, r_c;
    logic [31:0] r_prod;
    logic [5:0]  r_sh;
    logic [1:0]  r_mode;   // 0 zero, 1 sat, 2 byte, 3 product
    logic [7:0]  r_byte;
    logic [7:0]  n_val, r_val;

    logic [7:0]  e;
    logic [22:0] f;
    logic [8:0]  s9;

    always_comb begin
        e = i_bits[30:23];
        f = i_bits[22:0];
        n_c = '0;
        n_c.kind = i_kind;
        n_c.byte_val = i_bits[7:0];
        n_c.un16 = i_bits[15:0];
        s9 = 9'd150 - {1'b0, e};
        if (i_bits[31] || e == 8'hFF) begin
            n_c.zero = 1'b1;
        end else if (e == 8'd0) begin
            // A single-precision subnormal is far below half of one step of 1/255.
            n_c.zero = 1'b1;
        end else if (e >= 8'd127) begin
            n_c.sat = 1'b1;
        end else if (s9 > 9'd63) begin
            n_c.zero = 1'b1;
        end else begin
            n_c.mant = {1'b1, f};
            n_c.sh = s9[5:0];
        end
    end

    logic [31:0] n_prod;
    logic [1:0]  n_mode;
    logic [7:0]  n_byte;

    always_comb begin
        n_prod = {r_c.mant, 8'd0} - {8'd0, r_c.mant};
        n_byte = r_c.byte_val;
        n_mode = 2'd0;
        case (r_c.kind)
            K_ONE:  n_mode = 2'd1;
            K_BYTE: n_mode = 2'd2;
            K_UN16: begin
                // With the half step added in the last stage,
                // (u*255 + 127 + 2^15) >> 16 equals floor((2u+257)/514) for every u.
                n_mode = 2'd3;
                n_prod = ({16'd0, r_c.un16} << 8) - {16'd0, r_c.un16} + 32'd127;
            end
            K_FLOAT: begin
                if (r_c.sat) n_mode = 2'd1;
                else if (!r_c.zero) n_mode = 2'd3;
            end
            default: n_mode = 2'd0;
        endcase
    end

    logic [31:0] rnd;
    logic [32:0] shifted;
    always_comb begin
        rnd = (r_sh == 6'd0) ? 32'd0 : (32'd1 << (r_sh - 6'd1));
        // The sum needs a carry bit: a shift of 32 can still round up to one.
        shifted = ({1'b0, r_prod} + {1'b0, rnd}) >> r_sh;
        case (r_mode)
            2'd1:    n_val = 8'hFF;
            2'd2:    n_val = r_byte;
            2'd3:    n_val = shifted[7:0];
            default: n_val = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en0) r_c <= n_c;
        if (i_en1) begin
            r_prod <= n_prod;
            r_mode <= n_mode;
            r_byte <= n_byte;
            r_sh   <= (r_c.kind == K_UN16) ? 6'd16 : r_c.sh;
        end
        if (i_en2) r_val <= n_val;
    end

    assign o_val = r_val;
endmodule

[hdl/pixel_format_to_bgra8_convert.sv]
// Top level of the pixel format to BGRA8 unorm converter.
//   channel | direction | signals
//   input   | in        | i_start, o_busy, i_format_code, i_pixel_low, i_pixel_high
//   result  | out       | o_done, o_blue_out, o_green_out, o_red_out, o_alpha_out
// One item may start every cycle; o_busy stays low.
// The result appears with o_done high for one cycle,
// after three register stages: decode, scale by 255, round and shift.
// Reset clears the valid bits only; the receiver cannot stall the pipeline.
module pixel_format_to_bgra8_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [3:0]  i_format_code,
    input  logic [63:0] i_pixel_low,
    input  logic [63:0] i_pixel_high,
    output logic        o_done,
    output logic [7:0]  o_blue_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_alpha_out
);
    import pfc_pkg::*;

    logic [2:0] r_v;
    t_kind      k_r, k_g, k_b, k_a;
    logic [31:0] b_r, b_g, b_b, b_a;
    logic [31:0] w0, w1, w2, w3;
    logic [7:0] v_r, v_g, v_b, v_a;

    // Half float to single: sign, exponent rebias, mantissa widen.
    function automatic logic [31:0] h2s(input logic [15:0] h);
        logic [4:0] he;
        logic [9:0] hf;
        logic [31:0] s;
        he = h[14:10];
        hf = h[9:0];
        if (he == 5'h1F) s = {h[15], 8'hFF, 23'd0};
        else if (he == 5'd0) s = {h[15], 8'd0, 23'd0}; // subnormal: below 1/255/2
        else s = {h[15], 8'(he) + 8'd112, hf, 13'd0};
        return s;
    endfunction

    // Unsigned float with a 5-bit exponent to single.
    function automatic logic [31:0] u2s(input logic [4:0] ue, input logic [5:0] um);
        logic [31:0] s;
        if (ue == 5'h1F) s = {1'b0, 8'hFF, 23'd0};
        else if (ue == 5'd0) s = 32'd0;
        else s = {1'b0, 8'(ue) + 8'd112, um, 17'd0};
        return s;
    endfunction

    always_comb begin
        w0 = i_pixel_low[31:0];
        w1 = i_pixel_low[63:32];
        w2 = i_pixel_high[31:0];
        w3 = i_pixel_high[63:32];
        k_r = K_ZERO; k_g = K_ZERO; k_b = K_ZERO; k_a = K_ONE;
        b_r = '0; b_g = '0; b_b = '0; b_a = '0;
        case (t_fmt'(i_format_code))
            FMT_R8:    begin k_r = K_BYTE; b_r = w0; end
            FMT_RG8:   begin k_r = K_BYTE; b_r = w0; k_g = K_BYTE; b_g = {24'd0, w0[15:8]}; end
            FMT_R16U:  begin k_r = K_UN16; b_r = w0; end
            FMT_R16F:  begin k_r = K_FLOAT; b_r = h2s(w0[15:0]); end
            FMT_RG16U: begin
                k_r = K_UN16; b_r = w0; k_g = K_UN16; b_g = {16'd0, w0[31:16]};
            end
            FMT_RG16F: begin
                k_r = K_FLOAT; b_r = h2s(w0[15:0]); k_g = K_FLOAT; b_g = h2s(w0[31:16]);
            end
            FMT_RGBA16U: begin
                k_r = K_UN16; b_r = w0; k_g = K_UN16; b_g = {16'd0, w0[31:16]};
                k_b = K_UN16; b_b = w1; k_a = K_UN16; b_a = {16'd0, w1[31:16]};
            end
            FMT_RGBA16F: begin
                k_r = K_FLOAT; b_r = h2s(w0[15:0]); k_g = K_FLOAT; b_g = h2s(w0[31:16]);
                k_b = K_FLOAT; b_b = h2s(w1[15:0]); k_a = K_FLOAT; b_a = h2s(w1[31:16]);
            end
            FMT_R32F:  begin k_r = K_FLOAT; b_r = w0; end
            FMT_RG32F: begin k_r = K_FLOAT; b_r = w0; k_g = K_FLOAT; b_g = w1; end
            FMT_RGB32F: begin
                k_r = K_FLOAT; b_r = w0; k_g = K_FLOAT; b_g = w1; k_b = K_FLOAT; b_b = w2;
            end
            FMT_RGBA32F: begin
                k_r = K_FLOAT; b_r = w0; k_g = K_FLOAT; b_g = w1;
                k_b = K_FLOAT; b_b = w2; k_a = K_FLOAT; b_a = w3;
            end
            FMT_B10G11R11: begin
                k_r = K_FLOAT; b_r = u2s(w0[10:6], w0[5:0]);
                k_g = K_FLOAT; b_g = u2s(w0[21:17], w0[16:11]);
                k_b = K_FLOAT; b_b = u2s(w0[31:27], {w0[26:22], 1'b0});
            end
            default: begin
                k_r = K_BYTE; b_r = {24'd0, w0[23:16]};
                k_g = K_BYTE; b_g = {24'd0, w0[15:8]};
                k_b = K_BYTE; b_b = w0;
                k_a = K_BYTE; b_a = {24'd0, w0[31:24]};
            end
        endcase
    end

    logic en0, en1, en2;
    assign en0 = i_start;
    assign en1 = r_v[0];
    assign en2 = r_v[1];

    pfc_lane u_r (.i_clk, .i_en0(en0), .i_en1(en1), .i_en2(en2),
                  .i_kind(k_r), .i_bits(b_r), .o_val(v_r));
    pfc_lane u_g (.i_clk, .i_en0(en0), .i_en1(en1), .i_en2(en2),
                  .i_kind(k_g), .i_bits(b_g), .o_val(v_g));
    pfc_lane u_b (.i_clk, .i_en0(en0), .i_en1(en1), .i_en2(en2),
                  .i_kind(k_b), .i_bits(b_b), .o_val(v_b));
    pfc_lane u_a (.i_clk, .i_en0(en0), .i_en1(en1), .i_en2(en2),
                  .i_kind(k_a), .i_bits(b_a), .o_val(v_a));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[1:0], i_start};
        end
    end

    assign o_busy      = 1'b0;
    assign o_done      = r_v[2];
    assign o_red_out   = v_r;
    assign o_green_out = v_g;
    assign o_blue_out  = v_b;
    assign o_alpha_out = v_a;
endmodule

[hdl/pfc_checker.sv]
// Port-level checker for the pixel converter, bound to the top level.
module pfc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       o_busy,
    input logic       o_done,
    input logic [3:0] i_format_code,
    input logic [7:0] o_alpha_out
);
    import pfc_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy) else $error("busy raised");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##3 o_done) else $error("result missing");
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start, 3)) else $error("spurious result");
    a_alpha_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && (i_format_code == FMT_R8 || i_format_code == FMT_B10G11R11))
        |-> ##3 (o_alpha_out == 8'hFF)) else $error("alpha not one");
endmodule

bind pixel_format_to_bgra8_convert pfc_checker u_chk (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_done, .i_format_code, .o_alpha_out);

[test/tb.sv]
// Self-checking testbench for the pixel format to BGRA8 unorm converter.
`timescale 1ns / 100ps

module tb;
    import pfc_pkg::*;

    typedef struct {
        logic [3:0]  fmt;
        logic [63:0] lo;
        logic [63:0] hi;
    } t_pixel;

    typedef struct {
        logic [7:0] b, g, r, a;
    } t_bgra;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [3:0]  i_format_code;
    logic [63:0] i_pixel_low;
    logic [63:0] i_pixel_high;
    logic        o_done;
    logic [7:0]  o_blue_out, o_green_out, o_red_out, o_alpha_out;

    t_pixel pending_pixels[$];
    t_bgra  expected_bgra[$];
    int     mismatches = 0;
    int     converted = 0;
    int     sent = 0;
    int     gap = 0;
    bit     gaps_on = 1;
    longint cycles = 0;
    int     fmt_seen[16];

    pixel_format_to_bgra8_convert u_dut (.*);

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Exact round-half-up of m * 2^x * 255, saturating at 1.0.
    function automatic logic [7:0] scale_u8(logic [31:0] m, int x);
        logic [63:0] prod;
        int s;
        if (m == 0) return 8'd0;
        if (x >= 0) return 8'd255;
        s = -x;
        if (s > 63) return 8'd0;
        if (s < 32 && (m >> s) != 0) return 8'd255;
        prod = 64'(m) * 64'd255;
        return 8'((prod + (64'd1 << (s - 1))) >> s);
    endfunction

    function automatic logic [7:0] un16_u8(logic [15:0] u);
        return 8'((32'(u) * 2 + 257) / 514);
    endfunction

    function automatic logic [7:0] f32_u8(logic [31:0] v);
        if (v[31] || v[30:23] == 8'hFF) return 8'd0;
        if (v[30:23] == 0) return scale_u8({9'd0, v[22:0]}, -149);
        return scale_u8({8'd0, 1'b1, v[22:0]}, int'(v[30:23]) - 150);
    endfunction

    function automatic logic [7:0] f16_u8(logic [15:0] v);
        if (v[15] || v[14:10] == 5'h1F) return 8'd0;
        if (v[14:10] == 0) return scale_u8({22'd0, v[9:0]}, -24);
        return scale_u8({21'd0, 1'b1, v[9:0]}, int'(v[14:10]) - 25);
    endfunction

    // Unsigned float: 5-bit exponent above an mb-bit mantissa.
    function automatic logic [7:0] uf_u8(logic [10:0] v, int mb);
        logic [31:0] f;
        int e;
        f = 32'(v) & ((32'd1 << mb) - 1);
        e = int'((32'(v) >> mb) & 32'h1F);
        if (e == 31) return 8'd0;
        if (e == 0) return scale_u8(f, -14 - mb);
        return scale_u8(f | (32'd1 << mb), e - 15 - mb);
    endfunction

    function automatic t_bgra convert_pixel(t_pixel p);
        t_bgra o;
        logic [31:0] w0, w1, w2, w3;
        w0 = p.lo[31:0]; w1 = p.lo[63:32]; w2 = p.hi[31:0]; w3 = p.hi[63:32];
        o = '{b: 8'd0, g: 8'd0, r: 8'd0, a: 8'd255};
        case (t_fmt'(p.fmt))
            FMT_R8: o.r = w0[7:0];
            FMT_RG8: begin o.r = w0[7:0]; o.g = w0[15:8]; end
            FMT_R16U: o.r = un16_u8(w0[15:0]);
            FMT_R16F: o.r = f16_u8(w0[15:0]);
            FMT_RG16U: begin o.r = un16_u8(w0[15:0]); o.g = un16_u8(w0[31:16]); end
            FMT_RG16F: begin o.r = f16_u8(w0[15:0]); o.g = f16_u8(w0[31:16]); end
            FMT_RGBA16U: begin
                o.r = un16_u8(w0[15:0]); o.g = un16_u8(w0[31:16]);
                o.b = un16_u8(w1[15:0]); o.a = un16_u8(w1[31:16]);
            end
            FMT_RGBA16F: begin
                o.r = f16_u8(w0[15:0]); o.g = f16_u8(w0[31:16]);
                o.b = f16_u8(w1[15:0]); o.a = f16_u8(w1[31:16]);
            end
            FMT_R32F: o.r = f32_u8(w0);
            FMT_RG32F: begin o.r = f32_u8(w0); o.g = f32_u8(w1); end
            FMT_RGB32F: begin o.r = f32_u8(w0); o.g = f32_u8(w1); o.b = f32_u8(w2); end
            FMT_RGBA32F: begin
                o.r = f32_u8(w0); o.g = f32_u8(w1); o.b = f32_u8(w2); o.a = f32_u8(w3);
            end
            FMT_B10G11R11: begin
                o.r = uf_u8(w0[10:0], 6);
                o.g = uf_u8(w0[21:11], 6);
                o.b = uf_u8({1'b0, w0[31:22]}, 5);
            end
            default: o = '{b: w0[7:0], g: w0[15:8], r: w0[23:16], a: w0[31:24]};
        endcase
        return o;
    endfunction

    // Random float-like word: exponents clustered near 1.0 so rounding is exercised.
    function automatic logic [31:0] rand_f32();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0, 1, 2: v[30:23] = 8'($urandom_range(110, 127));
            3: v[30:23] = $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            default: ;
        endcase
        if ($urandom_range(0, 3) != 0) v[31] = 1'b0;
        return v;
    endfunction

    function automatic logic [15:0] rand_f16();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 5))
            0, 1, 2: v[14:10] = 5'($urandom_range(5, 15));
            3: v[14:10] = $urandom_range(0, 1) ? 5'h00 : 5'h1F;
            default: ;
        endcase
        if ($urandom_range(0, 3) != 0) v[15] = 1'b0;
        return v;
    endfunction

    function automatic logic [10:0] rand_uf(int mb);
        logic [10:0] v;
        v = 11'($urandom);
        if ($urandom_range(0, 2) != 0) v[mb +: 5] = 5'($urandom_range(7, 15));
        else if ($urandom_range(0, 1) != 0) v[mb +: 5] = $urandom_range(0, 1) ? 5'h0 : 5'h1F;
        if (mb == 5) v[10] = 1'b0;
        return v;
    endfunction

    function automatic t_pixel rand_pixel();
        t_pixel p;
        logic [10:0] ub;
        p.fmt = 4'($urandom_range(0, 15));
        p.lo = {$urandom, $urandom};
        p.hi = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0) begin
            if (p.fmt inside {FMT_R16F, FMT_RG16F, FMT_RGBA16F}) begin
                p.lo = {rand_f16(), rand_f16(), rand_f16(), rand_f16()};
            end else if (p.fmt inside {FMT_R32F, FMT_RG32F, FMT_RGB32F, FMT_RGBA32F}) begin
                p.lo = {rand_f32(), rand_f32()};
                p.hi = {rand_f32(), rand_f32()};
            end else if (p.fmt == FMT_B10G11R11) begin
                ub = rand_uf(5);
                p.lo[31:0] = {ub[9:0], rand_uf(6), rand_uf(6)};
            end
        end
        return p;
    endfunction

    initial begin
        t_pixel p;
        // Directed: every format at all-zero and all-ones, then special values.
        for (int f = 0; f < 16; f++) begin
            pending_pixels.push_back('{4'(f), 64'd0, 64'd0});
            pending_pixels.push_back('{4'(f), '1, '1});
        end
        // One, half, negative zero, infinity and NaN in single and half floats, then packed and 16-bit unsigned values.
        pending_pixels.push_back('{FMT_RGBA32F, {32'h3F80_0000, 32'h3F00_0000},
                                   {32'h8000_0000, 32'h7F80_0000}});
        pending_pixels.push_back('{FMT_RGBA32F, {32'h7FC0_0000, 32'h0000_0001},
                                   {32'h3F7F_FFFF, 32'h3B80_8081}});
        pending_pixels.push_back('{FMT_RGBA16F, {16'h3C00, 16'h3800, 16'h8000, 16'h7C00}, 64'd0});
        pending_pixels.push_back('{FMT_RGBA16F, {16'h7E00, 16'h0001, 16'h3BFF, 16'h1C04}, 64'd0});
        pending_pixels.push_back('{FMT_B10G11R11, {32'd0, 10'h3C0, 11'h7C0, 11'h3C0}, 64'd0});
        pending_pixels.push_back('{FMT_RGBA16U, {16'd128, 16'd129, 16'd385, 16'd65407}, 64'd0});
        for (int i = 0; i < 1350; i++) pending_pixels.push_back(rand_pixel());
    end

    task automatic p_accept();
        t_pixel q;
        q = '{i_format_code, i_pixel_low, i_pixel_high};
        expected_bgra.push_back(convert_pixel(q));
        fmt_seen[q.fmt]++;
        sent++;
    endtask

    // Driver: one item per accepted start, with random idle bursts.
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1) begin
            i_start <= 1'b0;
        end else begin
            if (i_start && !o_busy) begin
                p_accept();
            end
            if (i_start && o_busy) begin
                // Hold the current item until accepted.
            end else if (gap > 0) begin
                gap <= gap - 1;
                i_start <= 1'b0;
            end else if (gaps_on && i_start && $urandom_range(0, 5) == 0) begin
                gap <= $urandom_range(0, 2);
                i_start <= 1'b0;
            end else if (pending_pixels.size() > 0) begin
                t_pixel q;
                q = pending_pixels.pop_front();
                i_format_code <= q.fmt;
                i_pixel_low <= q.lo;
                i_pixel_high <= q.hi;
                i_start <= 1'b1;
                if (pending_pixels.size() < 200) gaps_on = 0;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: compare each strobed result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_bgra e;
            if (expected_bgra.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: result with nothing expected");
            end else begin
                e = expected_bgra.pop_front();
                converted++;
                if ({o_blue_out, o_green_out, o_red_out, o_alpha_out}
                        !== {e.b, e.g, e.r, e.a}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: item %0d BGRA exp %h %h %h %h got %h %h %h %h",
                                 converted - 1, e.b, e.g, e.r, e.a,
                                 o_blue_out, o_green_out, o_red_out, o_alpha_out);
                end
            end
        end
    end

    initial begin
        int codes_seen;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_format_code = '0;
        i_pixel_low = '0;
        i_pixel_high = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while ((pending_pixels.size() > 0 || i_start || expected_bgra.size() > 0)
               && cycles < 200000) begin
            @(posedge i_clk);
            cycles++;
        end
        repeat (10) @(posedge i_clk);
        if (cycles >= 200000) begin
            $display("pixel_format_to_bgra8_convert test failed");
        end else begin
            mismatches += expected_bgra.size();
            codes_seen = 0;
            foreach (fmt_seen[k]) if (fmt_seen[k] > 0) codes_seen++;
            $display("Converted %0d of %0d pixels over %0d format codes; %0d mismatches.",
                     converted, sent, codes_seen, mismatches);
            if (mismatches == 0) begin
                $display("pixel_format_to_bgra8_convert test passed");
            end else begin
                $display("pixel_format_to_bgra8_convert test failed");
            end
        end
        $finish;
    end
endmodule
